[rtl/cbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cbc_pkg;

    localparam int KSIZE_DEF      = 5;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int CHANNELS_DEF   = 3;

    localparam int REG_ROWS   = 5;
    localparam int REG_HALF   = 2;
    localparam int COEF_W     = 12;
    localparam int ROW_W      = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int SAMPLE_W   = 8;
    localparam int PROD_W     = SAMPLE_W + 1 + COEF_W;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CH_W       = 25;
    localparam int SUM_W      = 27;
    localparam int COL_W      = 10;
    localparam int ROW_OUT_W  = 12;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESERVE  = 3'd7;

    typedef logic [REG_ROWS-1:0][ROW_W-1:0] coef_rows_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic calc;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEO,
        ST_WRITE,
        ST_LOAD,
        ST_CALC,
        ST_OUT
    } state_t;

    // Tap at register row ry, column cx; zero outside the 5x5 register area.
    function automatic logic signed [COEF_W-1:0] tap_of(input coef_rows_t rows,
                                                        input int ry, input int cx);
        logic signed [COEF_W-1:0] t;
        t = '0;
        if (ry >= 0 && ry < REG_ROWS && cx >= 0 && cx < REG_ROWS)
        begin
            t = rows[ry[2:0]][COEF_W * cx[2:0] +: COEF_W];
        end
        return t;
    endfunction

endpackage
`default_nettype wire

[rtl/conv2d_clamped_border.sv]
// An item that yields a result passes the geometry, write, load and calc states before its
// result enters the output register; an item without a result goes back to idle after write.
// The next item is taken only when idle again, after the window is loaded through the single
// line store read port into the cell chain, the sum rippled down it and a stalled result taken.
// Reset (rst_n low, asynchronous) clears control state and restores the identity kernel,
// a 64 x 64 frame and preserve set; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_clamped_border import cbc_pkg::*; #(
    parameter int KSIZE      = KSIZE_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int CHANNELS   = CHANNELS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [SAMPLE_W-1:0]  pix_ch0,
    input  wire logic [SAMPLE_W-1:0]  pix_ch1,
    input  wire logic [SAMPLE_W-1:0]  pix_ch2,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [CH_W-1:0]           res_ch0,
    output logic [CH_W-1:0]           res_ch1,
    output logic [CH_W-1:0]           res_ch2,
    output logic [SUM_W-1:0]          res_sum,
    output logic [COL_W-1:0]          out_col,
    output logic [ROW_OUT_W-1:0]      out_row,
    output logic                      frame_end,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [ROW_W-1:0]     cfg_data
);

    localparam int HALF   = KSIZE / 2;
    localparam int NCELL  = KSIZE * KSIZE;
    localparam int DEPTH  = 2 * HALF * MAX_WIDTH + 2 * HALF + 1;
    localparam int A_W    = $clog2(DEPTH);
    localparam int S_W    = A_W + 2;
    localparam int PIX_W  = SAMPLE_W * CHANNELS;
    localparam int ACC_W  = PROD_W + $clog2(NCELL);
    localparam int EXT_W  = ACC_W + 2;
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int Y_W    = $clog2(MAX_HEIGHT);
    localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + HALF * MAX_WIDTH + HALF + 1);
    localparam int PW     = W_W + H_W;
    localparam int K_W    = $clog2(KSIZE);
    localparam int LC_W   = $clog2(NCELL + 1);
    localparam int D_W    = $clog2(KSIZE) + 1;
    localparam int GEO_W_RST = (64 > MAX_WIDTH) ? MAX_WIDTH : 64;
    localparam int GEO_H_RST = (64 > MAX_HEIGHT) ? MAX_HEIGHT : 64;
    localparam int CH_MAX = (1 << (CH_W - 1)) - 1;
    localparam int CH_MIN = -(1 << (CH_W - 1));
    // Identity kernel: centre tap of the centre row at 1.0.
    localparam coef_rows_t COEF_RST = {{2{ROW_W'(0)}}, 60'd4294967296, {2{ROW_W'(0)}}};

    // ---------------------------------------------------------------- registers
    state_t               state_reg, state_next;
    coef_rows_t           coef_reg;
    logic [FW_W-1:0]      fw_reg;
    logic [FH_W-1:0]      fh_reg;
    logic                 preserve_reg;
    logic [W_W-1:0]       geo_w_reg, geo_w_next;
    logic [H_W-1:0]       geo_h_reg, geo_h_next;
    logic [CNT_W-1:0]     total_reg, lag_reg, cnt_reg;
    logic [A_W-1:0]       wp_reg, rp_reg;
    logic [X_W-1:0]       ox_reg;
    logic [Y_W-1:0]       oy_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic                 wrap_reg;
    logic [LC_W-1:0]      ld_reg;
    logic [K_W-1:0]       dyi_reg, dxi_reg;
    logic                 out_valid_reg;
    logic [CH_W-1:0]      res0_reg, res1_reg, res2_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_OUT_W-1:0] row_reg;
    logic                 fend_reg;

    // ---------------------------------------------------------------- control outputs
    logic                 ram_we;
    cell_ctrl_t           cell_ctrl;
    logic                 out_fire;

    // ---------------------------------------------------------------- datapath nets
    logic [3*SAMPLE_W-1:0] pix_word;
    logic [PW-1:0]         area;
    logic [CNT_W-1:0]      lag_calc;
    logic [CNT_W:0]        cnt1;
    logic                  wrap;
    logic                  has_out;
    logic                  last_col, last_row;
    logic [Y_W+1:0]        r_off, r_clamp;
    logic [X_W+1:0]        c_off, c_clamp;
    logic [D_W-1:0]        dr, dc;
    logic signed [S_W-1:0] row_off, addr_s, addr_fix;
    logic [A_W-1:0]        rd_addr;
    logic [PIX_W-1:0]      rd_data;
    logic [CH_W-1:0]       res_sat [3];
    logic [SUM_W-1:0]      sum_calc;

    logic [NCELL-1:0][PIX_W-1:0]                pix_chain;
    logic [NCELL-1:0][CHANNELS-1:0][ACC_W-1:0]  acc_chain;

    assign pix_word = {pix_ch2, pix_ch1, pix_ch0};

    // Clamp the written geometry into the supported range; latched at frame start.
    always_comb
    begin
        if (fw_reg == '0)
            geo_w_next = W_W'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
            geo_w_next = W_W'(MAX_WIDTH);
        else
            geo_w_next = W_W'(fw_reg);

        if (fh_reg == '0)
            geo_h_next = H_W'(1);
        else if (32'(fh_reg) > 32'(MAX_HEIGHT))
            geo_h_next = H_W'(MAX_HEIGHT);
        else
            geo_h_next = H_W'(fh_reg);
    end

    assign area     = PW'(geo_w_reg) * PW'(geo_h_reg);
    assign lag_calc = CNT_W'(HALF) * CNT_W'(geo_w_reg) + CNT_W'(HALF);
    assign cnt1     = (CNT_W + 1)'(cnt_reg) + (CNT_W + 1)'(1);
    assign wrap     = cnt1 >= ((CNT_W + 1)'(total_reg) + (CNT_W + 1)'(lag_reg));
    assign has_out  = cnt_reg >= lag_reg;
    assign last_col = 32'(ox_reg) == 32'(geo_w_reg) - 32'd1;
    assign last_row = 32'(oy_reg) == 32'(geo_h_reg) - 32'd1;

    // Window address: clamp row and column of the current tap to the frame, then
    // offset from the output pixel's slot in the ring and fold back into range.
    always_comb
    begin
        r_off = (Y_W + 2)'(oy_reg) + (Y_W + 2)'(dyi_reg);
        if (r_off < (Y_W + 2)'(HALF))
            r_clamp = '0;
        else if (r_off - (Y_W + 2)'(HALF) >= (Y_W + 2)'(geo_h_reg))
            r_clamp = (Y_W + 2)'(geo_h_reg) - (Y_W + 2)'(1);
        else
            r_clamp = r_off - (Y_W + 2)'(HALF);

        c_off = (X_W + 2)'(ox_reg) + (X_W + 2)'(dxi_reg);
        if (c_off < (X_W + 2)'(HALF))
            c_clamp = '0;
        else if (c_off - (X_W + 2)'(HALF) >= (X_W + 2)'(geo_w_reg))
            c_clamp = (X_W + 2)'(geo_w_reg) - (X_W + 2)'(1);
        else
            c_clamp = c_off - (X_W + 2)'(HALF);
    end

    assign dr       = D_W'(r_clamp - (Y_W + 2)'(oy_reg));
    assign dc       = D_W'(c_clamp - (X_W + 2)'(ox_reg));
    assign row_off  = S_W'($signed(dr)) * S_W'($signed({1'b0, geo_w_reg}));
    assign addr_s   = S_W'($signed({1'b0, rp_reg})) + row_off + S_W'($signed(dc));

    always_comb
    begin
        if (addr_s < 0)
            addr_fix = addr_s + S_W'(DEPTH);
        else if (addr_s >= S_W'(DEPTH))
            addr_fix = addr_s - S_W'(DEPTH);
        else
            addr_fix = addr_s;
    end

    assign rd_addr = A_W'(addr_fix);

    // ---------------------------------------------------------------- line store
    cbc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (pix_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // ---------------------------------------------------------------- cell chain
    // Samples enter at cell 0 in tap order, so cell j ends up holding tap NCELL-1-j.
    // The partial sum flows from cell 0 to the last cell, one cell per cycle.
    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        localparam int K   = NCELL - 1 - j;
        localparam int DYI = K / KSIZE;
        localparam int DXI = K % KSIZE;

        logic [PIX_W-1:0]               pix_feed;
        logic [CHANNELS-1:0][ACC_W-1:0] acc_feed;

        if (j == 0)
        begin : g_head
            assign pix_feed = rd_data;
            assign acc_feed = '0;
        end
        else
        begin : g_body
            assign pix_feed = pix_chain[j-1];
            assign acc_feed = acc_chain[j-1];
        end

        cbc_cell #(
            .CHANNELS (CHANNELS),
            .ACC_W    (ACC_W),
            .RY       (DYI - HALF + REG_HALF),
            .CX       (DXI - HALF + REG_HALF)
        ) u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl),
            .coef    (coef_reg),
            .pix_in  (pix_feed),
            .pix_out (pix_chain[j]),
            .acc_in  (acc_feed),
            .acc_out (acc_chain[j])
        );
    end

    // Saturate each channel; missing channels read zero.
    for (genvar c = 0; c < 3; c++)
    begin : g_sat
        if (c < CHANNELS)
        begin : g_real
            logic signed [EXT_W-1:0] ext;
            assign ext = EXT_W'($signed(acc_chain[NCELL-1][c]));
            always_comb
            begin
                if (ext > EXT_W'(CH_MAX))
                    res_sat[c] = CH_W'(CH_MAX);
                else if (ext < EXT_W'(CH_MIN))
                    res_sat[c] = CH_W'(CH_MIN);
                else
                    res_sat[c] = CH_W'(ext);
            end
        end
        else
        begin : g_none
            assign res_sat[c] = '0;
        end
    end

    // Three saturated 25-bit values cannot leave the 27-bit range.
    assign sum_calc = SUM_W'($signed(res_sat[0])) + SUM_W'($signed(res_sat[1]))
                    + SUM_W'($signed(res_sat[2]));

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_GEO;
            ST_GEO:
                state_next = ST_WRITE;
            ST_WRITE:
                state_next = has_out ? ST_LOAD : ST_IDLE;
            ST_LOAD:
                if (ld_reg == LC_W'(NCELL))
                    state_next = ST_CALC;
            ST_CALC:
                if (ld_reg == LC_W'(NCELL - 1))
                    state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control outputs
    always_comb
    begin
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        cell_ctrl       = '0;
        out_fire        = 1'b0;
        case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_GEO:
                in_ready = 1'b0;
            ST_WRITE:
                ram_we = cnt_reg < total_reg;
            ST_LOAD:
            begin
                cell_ctrl.clear = 1'b1;
                cell_ctrl.shift = ld_reg != '0;
            end
            ST_CALC:
                cell_ctrl.calc = 1'b1;
            ST_OUT:
                out_fire = !out_valid_reg || out_ready;
            default:
                in_ready = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            coef_reg      <= COEF_RST;
            fw_reg        <= FW_W'(64);
            fh_reg        <= FH_W'(64);
            preserve_reg  <= 1'b1;
            geo_w_reg     <= W_W'(GEO_W_RST);
            geo_h_reg     <= H_W'(GEO_H_RST);
            total_reg     <= '0;
            lag_reg       <= '0;
            cnt_reg       <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            wrap_reg      <= 1'b0;
            ld_reg        <= '0;
            dyi_reg       <= '0;
            dxi_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_COEF_ROW0, REG_COEF_ROW1, REG_COEF_ROW2,
                    REG_COEF_ROW3, REG_COEF_ROW4:
                        coef_reg[cfg_idx] <= cfg_data;
                    REG_WIDTH:
                        fw_reg <= cfg_data[FW_W-1:0];
                    REG_HEIGHT:
                        fh_reg <= cfg_data[FH_W-1:0];
                    REG_PRESERVE:
                        preserve_reg <= cfg_data[0];
                    default:
                        preserve_reg <= preserve_reg;
                endcase
            end

            // Latch geometry only on the first item of a frame.
            if (in_valid && in_ready && cnt_reg == '0)
            begin
                geo_w_reg <= geo_w_next;
                geo_h_reg <= geo_h_next;
            end

            if (state_reg == ST_GEO)
            begin
                total_reg <= CNT_W'(area);
                lag_reg   <= lag_calc;
            end

            // Advance the item count and the write slot; restart both at frame end.
            if (state_reg == ST_WRITE)
            begin
                wrap_reg <= wrap;
                ld_reg   <= '0;
                dyi_reg  <= '0;
                dxi_reg  <= '0;
                if (wrap)
                begin
                    cnt_reg <= '0;
                    wp_reg  <= '0;
                end
                else
                begin
                    cnt_reg <= cnt1[CNT_W-1:0];
                    wp_reg  <= (wp_reg == A_W'(DEPTH - 1)) ? '0 : wp_reg + A_W'(1);
                end
            end

            // Walk the taps row by row while the chain takes in the read data.
            if (state_reg == ST_LOAD)
            begin
                if (ld_reg == LC_W'(NCELL))
                begin
                    ld_reg <= '0;
                end
                else
                begin
                    ld_reg <= ld_reg + LC_W'(1);
                    if (dxi_reg == K_W'(KSIZE - 1))
                    begin
                        dxi_reg <= '0;
                        dyi_reg <= dyi_reg + K_W'(1);
                    end
                    else
                    begin
                        dxi_reg <= dxi_reg + K_W'(1);
                    end
                end
            end

            if (state_reg == ST_CALC)
            begin
                ld_reg <= ld_reg + LC_W'(1);
            end

            // Hand the result to the output register and step the output position.
            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
                if (wrap_reg)
                begin
                    rp_reg <= '0;
                    ox_reg <= '0;
                    oy_reg <= '0;
                end
                else
                begin
                    rp_reg <= (rp_reg == A_W'(DEPTH - 1)) ? '0 : rp_reg + A_W'(1);
                    if (last_col)
                    begin
                        ox_reg <= '0;
                        oy_reg <= oy_reg + Y_W'(1);
                    end
                    else
                    begin
                        ox_reg <= ox_reg + X_W'(1);
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            res0_reg <= preserve_reg ? res_sat[0] : '0;
            res1_reg <= preserve_reg ? res_sat[1] : '0;
            res2_reg <= preserve_reg ? res_sat[2] : '0;
            sum_reg  <= sum_calc;
            col_reg  <= COL_W'(ox_reg);
            row_reg  <= ROW_OUT_W'(oy_reg);
            fend_reg <= last_col && last_row;
        end
        if (in_valid && in_ready)
        begin
            pix_reg <= pix_word[PIX_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign res_ch0   = res0_reg;
    assign res_ch1   = res1_reg;
    assign res_ch2   = res2_reg;
    assign res_sum   = sum_reg;
    assign out_col   = col_reg;
    assign out_row   = row_reg;
    assign frame_end = fend_reg;

endmodule
`default_nettype wire

[rtl/cbc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module cbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4101
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/cbc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module cbc_cell import cbc_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int ACC_W    = 26,
    parameter int RY       = 0,
    parameter int CX       = 0
) (
    input  wire logic                                clk,
    input  wire cell_ctrl_t                          ctrl,
    input  wire coef_rows_t                          coef,
    input  wire logic [SAMPLE_W*CHANNELS-1:0]        pix_in,
    output logic      [SAMPLE_W*CHANNELS-1:0]        pix_out,
    input  wire logic [CHANNELS-1:0][ACC_W-1:0]      acc_in,
    output logic      [CHANNELS-1:0][ACC_W-1:0]      acc_out
);

    logic [SAMPLE_W*CHANNELS-1:0]   pix_reg;
    logic [CHANNELS-1:0][ACC_W-1:0] acc_reg;
    logic [CHANNELS-1:0][ACC_W-1:0] acc_next;
    logic signed [COEF_W-1:0]       tap;

    assign tap = tap_of(coef, RY, CX);

    // Multiply the held sample by this cell's tap and add the neighbor's partial sum.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        logic signed [PROD_W-1:0] prod;
        assign prod = $signed({1'b0, pix_reg[SAMPLE_W*c +: SAMPLE_W]}) * tap;
        assign acc_next[c] = $signed(acc_in[c]) + ACC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            pix_reg <= pix_in;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.calc)
        begin
            acc_reg <= acc_next;
        end
    end

    assign pix_out = pix_reg;
    assign acc_out = acc_reg;

endmodule
`default_nettype wire

[rtl/cbc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module cbc_checker import cbc_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [SUM_W-1:0] res_sum
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_sum))
        else $error("stalled result changed");

    // One item at a time: busy right after an accept.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // A result never shows up in the cycle after its item is taken.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // Reset empties the output register.
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind conv2d_clamped_border cbc_checker u_cbc_checker (.*);
`default_nettype wire

[bench/conv2d_clamped_border_chk.sv]
`timescale 1ns / 1ps
module conv2d_clamped_border_chk import cbc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [SAMPLE_W-1:0]  pix_ch0,
    input  logic [SAMPLE_W-1:0]  pix_ch1,
    input  logic [SAMPLE_W-1:0]  pix_ch2,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [CH_W-1:0]      res_ch0,
    input  logic [CH_W-1:0]      res_ch1,
    input  logic [CH_W-1:0]      res_ch2,
    input  logic [SUM_W-1:0]     res_sum,
    input  logic [COL_W-1:0]     out_col,
    input  logic [ROW_OUT_W-1:0] out_row,
    input  logic                 frame_end,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [ROW_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);
    localparam int RING = 4 * MAX_WIDTH_DEF + 5;

    typedef struct packed {
        logic [CH_W-1:0]      c0;
        logic [CH_W-1:0]      c1;
        logic [CH_W-1:0]      c2;
        logic [SUM_W-1:0]     sum;
        logic [COL_W-1:0]     col;
        logic [ROW_OUT_W-1:0] row;
        logic                 fend;
    } pix_result_t;

    pix_result_t      filtered_q[$];
    logic [ROW_W-1:0] kern [REG_ROWS];
    logic [FW_W-1:0]  cfg_w;
    logic [FH_W-1:0]  cfg_h;
    logic             keep_ch;
    logic [23:0]      pix_ring [RING];
    int unsigned      pos, geo_w, geo_h;

    function automatic int unsigned fit_dim(int unsigned v, int unsigned maxv);
        if (v < 1)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Run one accepted pixel through the convolution and queue its result, if any.
    task automatic filter_pixel(input logic [23:0] word);
        int unsigned w, h, tot, lag, n, p, x, y;
        int r, c;
        longint acc, sum;
        logic signed [COEF_W-1:0] tap;
        logic [CH_W-1:0] chv [3];
        pix_result_t e;
        if (pos == 0)
        begin
            geo_w = fit_dim(cfg_w, MAX_WIDTH_DEF);
            geo_h = fit_dim(cfg_h, MAX_HEIGHT_DEF);
        end
        w = geo_w;
        h = geo_h;
        tot = w * h;
        lag = 2 * w + 2;
        n = pos;
        if (n < tot)
            pix_ring[n % RING] = word;
        pos = n + 1;
        if (pos >= tot + lag)
            pos = 0;
        if (n < lag)
            return;
        p = n - lag;
        x = p % w;
        y = p / w;
        sum = 0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 0;
            for (int dy = -2; dy <= 2; dy++)
            begin
                r = int'(y) + dy;
                r = (r < 0) ? 0 : ((r > int'(h) - 1) ? int'(h) - 1 : r);
                for (int dx = -2; dx <= 2; dx++)
                begin
                    c = int'(x) + dx;
                    c = (c < 0) ? 0 : ((c > int'(w) - 1) ? int'(w) - 1 : c);
                    tap = kern[dy + 2][COEF_W * (dx + 2) +: COEF_W];
                    acc += longint'(pix_ring[(r * w + c) % RING][8 * ch +: 8])
                           * longint'(tap);
                end
            end
            acc = sat(acc, -16777216, 16777215);
            sum += acc;
            chv[ch] = keep_ch ? acc[CH_W-1:0] : '0;
        end
        sum = sat(sum, -67108864, 67108863);
        e.c0 = chv[0];
        e.c1 = chv[1];
        e.c2 = chv[2];
        e.sum = sum[SUM_W-1:0];
        e.col = x[COL_W-1:0];
        e.row = y[ROW_OUT_W-1:0];
        e.fend = (p == tot - 1);
        filtered_q.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pix_result_t e;
        int bad;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_ROWS; i++)
                kern[i] <= (i == 2) ? 60'd4294967296 : ROW_W'(0);
            cfg_w <= FW_W'(64);
            cfg_h <= FH_W'(64);
            keep_ch <= 1'b1;
            pos = 0;
            geo_w = 64;
            geo_h = 64;
            filtered_q.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_COEF_ROW0, REG_COEF_ROW1, REG_COEF_ROW2,
                    REG_COEF_ROW3, REG_COEF_ROW4: kern[cfg_idx] <= cfg_data;
                    REG_WIDTH:    cfg_w <= cfg_data[FW_W-1:0];
                    REG_HEIGHT:   cfg_h <= cfg_data[FH_W-1:0];
                    REG_PRESERVE: keep_ch <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: unexpected result col %0d row %0d", $time, out_col, out_row);
                    bad++;
                end
                else
                begin
                    e = filtered_q.pop_front();
                    if (e != {res_ch0, res_ch1, res_ch2, res_sum, out_col, out_row, frame_end})
                    begin
                        $display("%0t: mismatch expected ch %h %h %h sum %h col %0d row %0d end %b",
                                 $time, e.c0, e.c1, e.c2, e.sum, e.col, e.row, e.fend);
                        $display("%0t:          actual ch %h %h %h sum %h col %0d row %0d end %b",
                                 $time, res_ch0, res_ch1, res_ch2, res_sum, out_col, out_row,
                                 frame_end);
                        bad++;
                    end
                end
            end
            if (in_valid && in_ready)
                filter_pixel({pix_ch2, pix_ch1, pix_ch0});
            errors <= errors + bad;
            pending <= filtered_q.size();
        end
    end

endmodule

[bench/conv2d_clamped_border_tb.sv]
`timescale 1ns / 1ps
module conv2d_clamped_border_tb;
    import cbc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  pix_ch0;
    logic [SAMPLE_W-1:0]  pix_ch1;
    logic [SAMPLE_W-1:0]  pix_ch2;
    logic                 out_valid;
    logic                 out_ready;
    logic [CH_W-1:0]      res_ch0;
    logic [CH_W-1:0]      res_ch1;
    logic [CH_W-1:0]      res_ch2;
    logic [SUM_W-1:0]     res_sum;
    logic [COL_W-1:0]     out_col;
    logic [ROW_OUT_W-1:0] out_row;
    logic                 frame_end;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [ROW_W-1:0]     cfg_data;
    int                   errors;
    int                   pending;
    int                   burst_left;
    int                   sent;
    bit                   steady_rx;

    // Pixel patterns for a frame.
    typedef enum int { PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_CHECKER } pat_t;

    localparam logic [ROW_W-1:0] KERN_MAX = {5{12'h7FF}};
    localparam logic [ROW_W-1:0] KERN_MIN = {5{12'h800}};

    conv2d_clamped_border uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pix_ch0(pix_ch0), .pix_ch1(pix_ch1), .pix_ch2(pix_ch2),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_ch0(res_ch0), .res_ch1(res_ch1), .res_ch2(res_ch2), .res_sum(res_sum),
        .out_col(out_col), .out_row(out_row), .frame_end(frame_end),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    conv2d_clamped_border_chk chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pix_ch0(pix_ch0), .pix_ch1(pix_ch1), .pix_ch2(pix_ch2),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_ch0(res_ch0), .res_ch1(res_ch1), .res_ch2(res_ch2), .res_sum(res_sum),
        .out_col(out_col), .out_row(out_row), .frame_end(frame_end),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Receiver: alternate between a steady phase and a phase with random stalls,
    // so back-pressure lands on every point of the block's result cycle.
    initial
    begin
        out_ready = 1'b1;
        steady_rx = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                steady_rx = ~steady_rx;
            out_ready = steady_rx ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // Write one register for a single cycle; called only while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_kernel(input logic [ROW_W-1:0] row0, input logic [ROW_W-1:0] row1,
                                input logic [ROW_W-1:0] row2, input logic [ROW_W-1:0] row3,
                                input logic [ROW_W-1:0] row4);
        write_reg(REG_COEF_ROW0, row0);
        write_reg(REG_COEF_ROW1, row1);
        write_reg(REG_COEF_ROW2, row2);
        write_reg(REG_COEF_ROW3, row3);
        write_reg(REG_COEF_ROW4, row4);
    endtask

    function automatic logic [ROW_W-1:0] rand_row();
        return ROW_W'({$urandom, $urandom});
    endfunction

    // Offer one item and hold it until the block takes it. Between bursts,
    // drop valid for a random gap first; the gap may be empty.
    task automatic push_pixel(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid = 1'b1;
        pix_ch0 = c0;
        pix_ch1 = c1;
        pix_ch2 = c2;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        sent++;
        @(negedge clk);
    endtask

    // Stream one whole frame plus the padding items that flush its last rows.
    task automatic send_frame(input int w, input int h, input pat_t pat);
        logic [7:0] v;
        for (int i = 0; i < w * h + 2 * w + 2; i++)
        begin
            case (pat)
                PAT_WHITE:   v = 8'hFF;
                PAT_BLACK:   v = 8'h00;
                PAT_CHECKER: v = ((i % w + i / w) % 2) ? 8'hFF : 8'h00;
                default:     v = 8'h00;
            endcase
            if (pat == PAT_RANDOM)
                push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            else
                push_pixel(v, ~v, v);
        end
    endtask

    // Let every expected result arrive, then let the block settle before a write.
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_frame(input int w, input int h, input pat_t pat);
        write_reg(REG_WIDTH, ROW_W'(w));
        write_reg(REG_HEIGHT, ROW_W'(h));
        send_frame(w < 1 ? 1 : (w > 1024 ? 1024 : w), h < 1 ? 1 : (h > 4096 ? 4096 : h), pat);
        drain();
    endtask

    initial
    begin
        int w;
        int h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pix_ch0 = '0;
        pix_ch1 = '0;
        pix_ch2 = '0;
        cfg_we = 1'b0;
        cfg_idx = REG_COEF_ROW0;
        cfg_data = '0;
        burst_left = 0;
        sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset kernel on a tiny frame, then the tap extremes on white-pattern
        // frames, with and without per-channel results, then a black-pattern frame.
        run_frame(2, 2, PAT_CHECKER);
        write_kernel(KERN_MAX, KERN_MAX, KERN_MAX, KERN_MAX, KERN_MAX);
        write_reg(REG_PRESERVE, ROW_W'(1));
        run_frame(3, 1, PAT_WHITE);
        write_kernel(KERN_MIN, KERN_MIN, KERN_MIN, KERN_MIN, KERN_MIN);
        write_reg(REG_PRESERVE, ROW_W'(0));
        run_frame(1, 1, PAT_WHITE);
        write_reg(REG_PRESERVE, ROW_W'(1));
        run_frame(1, 2, PAT_BLACK);

        // Random kernels on small frames; a few wider ones.
        while (sent < 1000)
        begin
            write_kernel(rand_row(), rand_row(), rand_row(), rand_row(), rand_row());
            write_reg(REG_PRESERVE, ROW_W'($urandom_range(0, 3) != 0));
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            run_frame(w, h, ($urandom_range(0, 5) == 0) ? PAT_CHECKER : PAT_RANDOM);
        end

        // Geometry out of range: zero height, then zero width.
        write_kernel(rand_row(), rand_row(), rand_row(), rand_row(), rand_row());
        run_frame(7, 0, PAT_RANDOM);
        run_frame(0, 9, PAT_RANDOM);

        if (errors == 0)
            $display("** conv2d_clamped_border: PASSED **");
        else
            $display("** conv2d_clamped_border: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #25_000_000;
        $display("** conv2d_clamped_border: FAILED **");
        $finish;
    end

endmodule
